@@ src/weighted_ema_sensor_fusion_core_defines.svh @@
// ----------------------------------------------------------------------------
// Weighted EMA sensor fusion - assertion macros
// Shared concurrent assertion wrappers for the checker.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_EMA_SENSOR_FUSION_CORE_DEFINES_SVH
`define WEIGHTED_EMA_SENSOR_FUSION_CORE_DEFINES_SVH

// clocked on clk_i, muted while rst_ni is low
`define WEMSF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// clocked on clk_i, also checked during reset
`define WEMSF_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ src/wemsf_pkg.sv @@
// ----------------------------------------------------------------------------
// Weighted EMA sensor fusion - package
// Field widths, setup register layout, constants and sequencer types.
// ----------------------------------------------------------------------------
package wemsf_pkg;

  // channel field widths
  localparam int unsigned IDX_W     = 2;
  localparam int unsigned TEMP_W    = 19;
  localparam int unsigned OUT_W     = 21;
  localparam int unsigned CFG_W     = 38;
  localparam int unsigned CFG_IDX_W = 3;

  // setup register layout
  localparam int unsigned PM_W       = 10;
  localparam int unsigned ALPHA_LSB  = 0;
  localparam int unsigned WEIGHT_LSB = 10;
  localparam int unsigned OFFS_LSB   = 20;
  localparam int unsigned OFFS_W     = 18;

  localparam logic [CFG_W-1:0] SETUP0_RST = 38'd1025000;
  localparam logic [CFG_W-1:0] SETUPN_RST = 38'd1000;

  // datapath widths
  localparam int unsigned X_W     = 20;
  localparam int unsigned FILT_W  = 20;
  localparam int unsigned SUM_W   = 22;
  localparam int unsigned Q_W     = 21;
  localparam int unsigned MUL_W   = 32;
  localparam int unsigned PROD_W  = 64;

  localparam logic [PM_W-1:0] PER_MILLE = 10'd1000;

  // floor(m/1000) == (m * RECIP) >> RECIP_SHIFT, exact for m < 2**30
  localparam logic [MUL_W-1:0] RECIP       = 32'd1099511628;
  localparam int unsigned      RECIP_SHIFT = 40;

  // saturation limits
  localparam logic signed [FILT_W-1:0] FILT_MAX = 20'sh7FFFF;
  localparam logic signed [FILT_W-1:0] FILT_MIN = 20'sh80000;
  localparam logic signed [SUM_W-1:0]  SUM_MAX  = 22'sh1FFFFF;
  localparam logic signed [SUM_W-1:0]  SUM_MIN  = 22'sh200000;
  localparam logic signed [OUT_W-1:0]  OUT_MAX  = 21'shFFFFF;
  localparam logic signed [OUT_W-1:0]  OUT_MIN  = 21'sh100000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_NEW,
    ST_MUL_OLD,
    ST_ADD,
    ST_DIV_F,
    ST_FILT,
    ST_MUL_W,
    ST_DIV_W,
    ST_SUM
  } state_e;

  typedef enum logic [2:0] {
    OP_NEW,
    OP_OLD,
    OP_WGT,
    OP_DIV_ACC,
    OP_DIV_PROD
  } mul_op_e;

  typedef struct packed {
    logic    in_ready;
    logic    mul_en;
    mul_op_e mul_op;
    logic    acc_load;
    logic    acc_add;
    logic    filt_upd;
    logic    sum_upd;
  } ctrl_t;

endpackage

@@ src/wemsf_if.sv @@
// ----------------------------------------------------------------------------
// Weighted EMA sensor fusion - channel interfaces
// Reading, result and setup-write channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface wemsf_in_if import wemsf_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [IDX_W-1:0]         sensor_index;
  logic signed [TEMP_W-1:0] sensor_temp;
  logic                     last_sensor;

  modport source (output valid, sensor_index, sensor_temp, last_sensor, input ready);
  modport sink   (input valid, sensor_index, sensor_temp, last_sensor, output ready);
endinterface

interface wemsf_out_if import wemsf_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] combined_temp;

  modport source (output valid, combined_temp, input ready);
  modport sink   (input valid, combined_temp, output ready);
endinterface

interface wemsf_cfg_if import wemsf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [CFG_W-1:0]     reg_data;

  modport source (output valid, reg_index, reg_data, input ready);
  modport sink   (input valid, reg_index, reg_data, output ready);
endinterface

@@ src/wemsf_mul.sv @@
// ----------------------------------------------------------------------------
// Weighted EMA sensor fusion - shared multiplier
// Signed 32x32 multiply with a registered 64-bit product.
// ----------------------------------------------------------------------------
module wemsf_mul import wemsf_pkg::*; (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic signed [MUL_W-1:0]  a_i,
  input  logic signed [MUL_W-1:0]  b_i,
  output logic signed [PROD_W-1:0] p_o
);

  logic signed [PROD_W-1:0] prod_d, prod_q;

  assign prod_d = a_i * b_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign p_o = prod_q;

endmodule

@@ src/wemsf_seq.sv @@
// ----------------------------------------------------------------------------
// Weighted EMA sensor fusion - sequencer
// Steps one reading through the shared multiplier, one operation per cycle unless ST_SUM holds.
// ----------------------------------------------------------------------------
module wemsf_seq import wemsf_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,   // reading accepted
  input  logic  skip_i,    // index outside the sensor range
  input  logic  seeded_i,  // stored filter value is nonzero
  input  logic  hold_i,    // closing result cannot leave yet
  output ctrl_t ctrl_o
);

  state_e state_d, state_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = skip_i ? ST_SUM : ST_MUL_NEW;
        end
      end
      ST_MUL_NEW: state_d = seeded_i ? ST_MUL_OLD : ST_FILT;
      ST_MUL_OLD: state_d = ST_ADD;
      ST_ADD:     state_d = ST_DIV_F;
      ST_DIV_F:   state_d = ST_FILT;
      ST_FILT:    state_d = ST_MUL_W;
      ST_MUL_W:   state_d = ST_DIV_W;
      ST_DIV_W:   state_d = ST_SUM;
      ST_SUM:     state_d = hold_i ? ST_SUM : ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    ctrl_o.mul_op = OP_NEW;
    case (state_q)
      ST_IDLE: ctrl_o.in_ready = 1'b1;
      ST_MUL_NEW: begin
        ctrl_o.mul_en = 1'b1;
        ctrl_o.mul_op = OP_NEW;
      end
      ST_MUL_OLD: begin
        ctrl_o.mul_en   = 1'b1;
        ctrl_o.mul_op   = OP_OLD;
        ctrl_o.acc_load = 1'b1;
      end
      ST_ADD: ctrl_o.acc_add = 1'b1;
      ST_DIV_F: begin
        ctrl_o.mul_en = 1'b1;
        ctrl_o.mul_op = OP_DIV_ACC;
      end
      ST_FILT: ctrl_o.filt_upd = 1'b1;
      ST_MUL_W: begin
        ctrl_o.mul_en = 1'b1;
        ctrl_o.mul_op = OP_WGT;
      end
      ST_DIV_W: begin
        ctrl_o.mul_en = 1'b1;
        ctrl_o.mul_op = OP_DIV_PROD;
      end
      ST_SUM: ctrl_o.sum_upd = !hold_i;
      default: ctrl_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ src/weighted_ema_sensor_fusion_core.sv @@
// ----------------------------------------------------------------------------
// Weighted EMA sensor fusion core
// Virtual temperature sensor: per-sensor EMA filters feeding a weighted sum.
// ----------------------------------------------------------------------------
// Usage:
//   in_i   - one reading per request: sensor_index, sensor_temp (mC, signed)
//            and last_sensor, which closes the polling round.
//   out_o  - one combined_temp per closed round (weighted sum of filtered
//            readings, saturated to 21 bits signed).
//   cfg_i  - setup writes, reg_index 0..3 selects sensorN_setup; always
//            ready, higher indexes are dropped. Write only while idle.
// Timing: a reading runs through one shared 32x32 multiplier, one operation
//   per cycle unless a held result stalls it: seeded filters take MUL_NEW,
//   MUL_OLD, ADD, DIV_F, FILT, MUL_W, DIV_W, SUM; unseeded ones skip MUL_OLD,
//   ADD, DIV_F; an index outside MAX_SENSORS goes to SUM only. The next reading
//   waits for idle. A round's result is registered in its closing SUM step.
// Stalls: the result register frees the input side; the next reading is
//   taken while a result waits. A closing reading that finds the result
//   register still full waits in its final step until out_o.ready.
// Reset: filters and round sum clear to zero (zero filter = unseeded),
//   setup registers return to their defaults, result register empties.
// ----------------------------------------------------------------------------
module weighted_ema_sensor_fusion_core import wemsf_pkg::*; #(
  parameter int unsigned MAX_SENSORS = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  wemsf_in_if.sink     in_i,
  wemsf_out_if.source  out_o,
  wemsf_cfg_if.sink    cfg_i
);

  // index width into the per-sensor stores
  localparam int unsigned SEL_W = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;

  // -------------------------------------------------------------- saturation
  function automatic logic signed [FILT_W-1:0] sat_filt(input logic signed [Q_W-1:0] v);
    logic signed [FILT_W-1:0] r;
    if (v > Q_W'(FILT_MAX)) begin
      r = FILT_MAX;
    end else if (v < Q_W'(FILT_MIN)) begin
      r = FILT_MIN;
    end else begin
      r = FILT_W'(v);
    end
    return r;
  endfunction

  function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [SUM_W:0] v);
    logic signed [SUM_W-1:0] r;
    if (v > (SUM_W+1)'(SUM_MAX)) begin
      r = SUM_MAX;
    end else if (v < (SUM_W+1)'(SUM_MIN)) begin
      r = SUM_MIN;
    end else begin
      r = SUM_W'(v);
    end
    return r;
  endfunction

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [SUM_W-1:0] v);
    logic signed [OUT_W-1:0] r;
    if (v > SUM_W'(OUT_MAX)) begin
      r = OUT_MAX;
    end else if (v < SUM_W'(OUT_MIN)) begin
      r = OUT_MIN;
    end else begin
      r = OUT_W'(v);
    end
    return r;
  endfunction

  // ------------------------------------------------------------- signals
  ctrl_t ctrl;

  logic [CFG_W-1:0]         setup_q [MAX_SENSORS];
  logic signed [FILT_W-1:0] filt_q  [MAX_SENSORS];

  logic                     in_fire, cfg_fire, in_range, hold;
  logic [CFG_W-1:0]         setup_rd;
  logic [PM_W-1:0]          alpha_raw, alpha_c;
  logic signed [OFFS_W-1:0] offset;
  logic signed [X_W-1:0]    x_d;

  // per-reading context latched at accept
  logic [SEL_W-1:0]         idx_q;
  logic                     in_range_q, last_q;
  logic [PM_W-1:0]          alpha_q, beta_q, weight_q;
  logic signed [X_W-1:0]    x_q;
  logic signed [FILT_W-1:0] f_old_q, fnew_q;

  // arithmetic
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [MUL_W-1:0]  acc_q, div_src, div_mag;
  logic                     neg_q;
  logic [Q_W-1:0]           q_mag;
  logic signed [Q_W-1:0]    q_s, add_term;
  logic signed [FILT_W-1:0] fnew_d;
  logic signed [SUM_W-1:0]  round_sum_q, sum_new;

  logic                     out_valid_q;
  logic signed [OUT_W-1:0]  out_data_q;

  // ------------------------------------------------------------- handshakes
  assign in_i.ready  = ctrl.in_ready;
  assign cfg_i.ready = 1'b1;
  assign in_fire     = in_i.valid & in_i.ready;
  assign cfg_fire    = cfg_i.valid & cfg_i.ready;
  assign in_range    = 3'(in_i.sensor_index) < 3'(MAX_SENSORS);

  // closing reading cannot hand over while the previous result is unclaimed
  assign hold = last_q & out_valid_q & ~out_o.ready;

  wemsf_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (in_fire),
    .skip_i   (!in_range),
    .seeded_i (f_old_q != '0),
    .hold_i   (hold),
    .ctrl_o   (ctrl)
  );

  // ------------------------------------------------------------- setup regs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_SENSORS; i++) begin
        setup_q[i] <= (i == 0) ? SETUP0_RST : SETUPN_RST;
      end
    end else if (cfg_fire && (cfg_i.reg_index < CFG_IDX_W'(MAX_SENSORS))) begin
      setup_q[cfg_i.reg_index[SEL_W-1:0]] <= cfg_i.reg_data;
    end
  end

  // ------------------------------------------------------------- accept stage
  assign setup_rd  = setup_q[in_i.sensor_index[SEL_W-1:0]];
  assign alpha_raw = setup_rd[ALPHA_LSB +: PM_W];
  assign alpha_c   = (alpha_raw > PER_MILLE) ? PER_MILLE : alpha_raw;  // cap at full weight
  assign offset    = $signed(setup_rd[OFFS_LSB +: OFFS_W]);
  assign x_d       = X_W'(in_i.sensor_temp) - X_W'(offset);

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      idx_q    <= in_i.sensor_index[SEL_W-1:0];
      alpha_q  <= alpha_c;
      beta_q   <= PER_MILLE - alpha_c;
      weight_q <= setup_rd[WEIGHT_LSB +: PM_W];
      x_q      <= x_d;
      f_old_q  <= in_range ? filt_q[in_i.sensor_index[SEL_W-1:0]] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_range_q <= 1'b0;
      last_q     <= 1'b0;
    end else if (in_fire) begin
      in_range_q <= in_range;
      last_q     <= in_i.last_sensor;
    end
  end

  // ------------------------------------------------------------- shared multiplier
  // divide steps take the magnitude; the sign is reapplied to the quotient
  assign div_src = (ctrl.mul_op == OP_DIV_ACC) ? acc_q : prod[MUL_W-1:0];
  assign div_mag = div_src[MUL_W-1] ? -div_src : div_src;

  always_comb begin
    case (ctrl.mul_op)
      OP_NEW: begin
        mul_a = MUL_W'(alpha_q);
        mul_b = MUL_W'(x_q);
      end
      OP_OLD: begin
        mul_a = MUL_W'(beta_q);
        mul_b = MUL_W'(f_old_q);
      end
      OP_WGT: begin
        mul_a = MUL_W'(weight_q);
        mul_b = MUL_W'(fnew_q);
      end
      OP_DIV_ACC, OP_DIV_PROD: begin
        mul_a = div_mag;
        mul_b = RECIP;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  wemsf_mul u_mul (
    .clk_i (clk_i),
    .en_i  (ctrl.mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // blend accumulator and quotient sign
  always_ff @(posedge clk_i) begin
    if (ctrl.acc_load) begin
      acc_q <= prod[MUL_W-1:0];
    end else if (ctrl.acc_add) begin
      acc_q <= acc_q + prod[MUL_W-1:0];
    end
    if (ctrl.mul_en && (ctrl.mul_op == OP_DIV_ACC || ctrl.mul_op == OP_DIV_PROD)) begin
      neg_q <= div_src[MUL_W-1];
    end
  end

  // quotient after a divide step, truncated toward zero
  assign q_mag = prod[RECIP_SHIFT+Q_W-1:RECIP_SHIFT];
  assign q_s   = neg_q ? -$signed(q_mag) : $signed(q_mag);

  // ------------------------------------------------------------- filter update
  // unseeded filter loads the reading directly
  assign fnew_d = (f_old_q != '0) ? sat_filt(q_s) : x_q;

  always_ff @(posedge clk_i) begin
    if (ctrl.filt_upd) begin
      fnew_q <= fnew_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_SENSORS; i++) begin
        filt_q[i] <= '0;
      end
    end else if (ctrl.filt_upd) begin
      filt_q[idx_q] <= fnew_d;
    end
  end

  // ------------------------------------------------------------- round sum / result
  assign add_term = in_range_q ? q_s : '0;
  assign sum_new  = sat_sum((SUM_W+1)'(round_sum_q) + (SUM_W+1)'(add_term));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      round_sum_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // a new result may replace the one leaving this cycle
      if (ctrl.sum_upd && last_q) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (ctrl.sum_upd) begin
        if (last_q) begin
          round_sum_q <= '0;
        end else begin
          round_sum_q <= sum_new;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.sum_upd && last_q) begin
      out_data_q <= sat_out(sum_new);
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.combined_temp = out_data_q;

endmodule

@@ src/wemsf_chk.sv @@
// ----------------------------------------------------------------------------
// Weighted EMA sensor fusion - port checker
// Port-level assertions, bound to the core.
// ----------------------------------------------------------------------------
`include "weighted_ema_sensor_fusion_core_defines.svh"

module wemsf_chk import wemsf_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_i,
  input logic                    out_valid_i,
  input logic                    out_ready_i,
  input logic signed [OUT_W-1:0] out_data_i
);

  // a waiting result holds its value
  `WEMSF_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i), "result dropped or changed while stalled")

  // one reading at a time
  `WEMSF_ASSERT(a_busy_after_accept, in_valid_i && in_ready_i |=> !in_ready_i, "request taken while busy")

  // a result is produced on the last step, which returns to idle
  `WEMSF_ASSERT(a_result_then_idle, $rose(out_valid_i) |-> in_ready_i, "result raised without returning to idle")

  // reset empties the result register
  `WEMSF_ASSERT_RST(a_reset_empty, !rst_ni |=> !out_valid_i, "result valid during reset")

endmodule

bind weighted_ema_sensor_fusion_core wemsf_chk u_wemsf_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.combined_temp)
);
